### rtl/core/assert_macros.svh
// Assertion macros for the core RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define FDRC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define FDRC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/core/fdrc_pkg.sv
// Shared field widths, codes and types of the distinct range counter.
package fdrc_pkg;

    // Payload field widths
    localparam int REQ_TYPE_W = 1;
    localparam int VALUE_W    = 10;
    localparam int POS_W      = 11;
    localparam int COUNT_W    = 11;
    localparam int STATUS_W   = 2;

    // Request kinds
    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_PUSH  = 1'b0,
        REQ_QUERY = 1'b1
    } t_req_type;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    // Shared adder operations
    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

endpackage

### rtl/core/fdrc_if.sv
// Request and response channel interfaces of the distinct range counter.
interface fdrc_req_if;
    import fdrc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [VALUE_W-1:0]    elem_value;
    logic [POS_W-1:0]      left_pos;
    logic [POS_W-1:0]      right_pos;

    modport source (output valid, req_type, elem_value, left_pos, right_pos, input ready);
    modport sink   (input valid, req_type, elem_value, left_pos, right_pos, output ready);
endinterface

interface fdrc_rsp_if;
    import fdrc_pkg::*;

    logic                valid;
    logic                ready;
    logic [COUNT_W-1:0]  distinct_count;
    logic [STATUS_W-1:0] status;

    modport source (output valid, distinct_count, status, input ready);
    modport sink   (input valid, distinct_count, status, output ready);
endinterface

### rtl/core/fdrc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module fdrc_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read, old data on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/fdrc_alu.sv
// Shared add/subtract unit used by the sequencer.
module fdrc_alu #(
    parameter int WIDTH = 20
) (
    input  fdrc_pkg::t_alu_op i_op,
    input  logic [WIDTH-1:0]  i_a,
    input  logic [WIDTH-1:0]  i_b,
    output logic [WIDTH-1:0]  o_y,
    output logic              o_borrow
);
    import fdrc_pkg::*;

    logic [WIDTH:0] w_sum;

    // One adder; subtraction through the inverted operand and carry in
    always_comb begin
        unique case (i_op)
            ALU_ADD: w_sum = {1'b0, i_a} + {1'b0, i_b};
            ALU_SUB: w_sum = {1'b0, i_a} + {1'b0, ~i_b} + {{WIDTH{1'b0}}, 1'b1};
            default: w_sum = '0;
        endcase
    end

    assign o_y      = w_sum[WIDTH-1:0];
    assign o_borrow = (i_op == ALU_SUB) ? !w_sum[WIDTH] : 1'b0;

endmodule

### rtl/core/fenwick_distinct_range_count_core.sv
// Distinct-value range counter: a Fenwick tree over stream positions, walked one node a cycle.
// After reset the block first clears both stores, one entry a cycle, over
// max(MAX_ELEMS+1, VALUE_RANGE) addresses, and takes no request meanwhile.
// Then it handles one request at a time. A push steps through accept, a reduction (quotient,
// then remainder) when VALUE_RANGE is below 1024, a last-position lookup, a decrement walk up
// the tree from the value's earlier position and a turnaround (both skipped if it was never
// seen), an increment walk from the new position, and posting of the result. A query steps
// through accept, popcount(right_pos) plus popcount(left_pos-1) prefix steps, a subtract and
// posting of the result. A full push or a bad query goes from accept straight to posting.
// Every push walk step is one read and one write of the tree RAM; a query step only reads it.
// The result sits in an output register, so a request is taken while the previous result waits.
`include "assert_macros.svh"

module fenwick_distinct_range_count_core #(
    parameter int MAX_ELEMS   = 1024,
    parameter int VALUE_RANGE = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fdrc_req_if.sink    i_req,
    fdrc_rsp_if.source  o_rsp
);
    import fdrc_pkg::*;

    // Derived widths
    localparam int PW      = $clog2(MAX_ELEMS + 1);        // position / fill
    localparam int IW      = PW + 1;                       // walk index, may pass MAX_ELEMS
    localparam int CW      = $clog2(MAX_ELEMS + 1);        // tree node count
    localparam int TD      = MAX_ELEMS + 1;                // tree depth, index 0 unused
    localparam int TW      = $clog2(TD);
    localparam int LW      = $clog2(VALUE_RANGE);
    localparam int VW      = VALUE_W;
    localparam int ALW     = (CW > 2 * VW) ? CW : 2 * VW;
    localparam int CMPW    = (PW > POS_W) ? PW : POS_W;
    localparam int CLR_N   = (TD > VALUE_RANGE) ? TD : VALUE_RANGE;
    localparam int CLRW    = $clog2(CLR_N);
    localparam bit MOD_REQ = (VALUE_RANGE < (1 << VW));
    localparam logic [ALW-1:0] VR_A = ALW'(VALUE_RANGE);

    // Reciprocal of VALUE_RANGE, exact quotient for every value below 2**VW
    localparam int     MW   = VW + 1;
    localparam int     PRW  = VW + MW;
    localparam int     RS   = VW + $clog2(VALUE_RANGE);
    localparam longint RM   = ((longint'(1) << RS) + VALUE_RANGE - 1) / VALUE_RANGE;
    localparam logic [MW-1:0] RM_V = MW'(RM);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_MODSUB,
        S_LPCHK,
        S_DEC,
        S_INCSET,
        S_INC,
        S_QA,
        S_QB,
        S_QSUB,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [CLRW-1:0]     r_clr, n_clr;
    logic [PW-1:0]       r_fill, n_fill;
    logic [IW-1:0]       r_pos, n_pos;
    logic [VW-1:0]       r_slot, n_slot;
    logic [VW-1:0]       r_quo, n_quo;
    logic [CW-1:0]       r_acc, n_acc;
    logic [CW-1:0]       r_suma, n_suma;
    logic [PW-1:0]       r_lm1, n_lm1;
    logic [COUNT_W-1:0]  r_res_cnt, n_res_cnt;
    t_status             r_res_st, n_res_st;
    logic                r_ovalid, n_ovalid;
    logic [COUNT_W-1:0]  r_ocount, n_ocount;
    t_status             r_ostatus, n_ostatus;

    // Memory ports
    logic                tree_we;
    logic [TW-1:0]       tree_waddr, tree_raddr;
    logic [CW-1:0]       tree_wdata, tree_rdata;
    logic                lp_we;
    logic [LW-1:0]       lp_waddr, lp_raddr;
    logic [PW-1:0]       lp_wdata, lp_rdata;

    // Shared adder
    t_alu_op             alu_op;
    logic [ALW-1:0]      alu_a, alu_b, alu_y;
    logic                alu_borrow;

    // Walk index steps
    logic [IW-1:0]       w_lb, w_pos_up, w_pos_dn;
    logic                w_accept, w_bad;

    // Value reduction terms
    logic [PRW-1:0]      w_prod;
    logic [VW-1:0]       w_quo;
    logic [ALW-1:0]      w_quo_vr;

    fdrc_ram #(.WIDTH(CW), .DEPTH(TD)) u_tree_ram (
        .i_clk   (i_clk),
        .i_we    (tree_we),
        .i_waddr (tree_waddr),
        .i_wdata (tree_wdata),
        .i_raddr (tree_raddr),
        .o_rdata (tree_rdata)
    );

    fdrc_ram #(.WIDTH(PW), .DEPTH(VALUE_RANGE)) u_last_ram (
        .i_clk   (i_clk),
        .i_we    (lp_we),
        .i_waddr (lp_waddr),
        .i_wdata (lp_wdata),
        .i_raddr (lp_raddr),
        .o_rdata (lp_rdata)
    );

    fdrc_alu #(.WIDTH(ALW)) u_alu (
        .i_op     (alu_op),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_y      (alu_y),
        .o_borrow (alu_borrow)
    );

    // Handshake and output payload
    assign i_req.ready          = (r_state == S_IDLE);
    assign w_accept             = i_req.valid && i_req.ready;
    assign o_rsp.valid          = r_ovalid;
    assign o_rsp.distinct_count = r_ocount;
    assign o_rsp.status         = r_ostatus;

    // Lowest set bit and the two Fenwick neighbors of the current index
    assign w_lb     = r_pos & (~r_pos + IW'(1));
    assign w_pos_up = r_pos + w_lb;
    assign w_pos_dn = r_pos - w_lb;

    // Quotient by reciprocal multiply, then quotient times VALUE_RANGE for the subtract
    assign w_prod   = PRW'(r_slot) * PRW'(RM_V);
    assign w_quo    = VW'(w_prod >> RS);
    assign w_quo_vr = ALW'(r_quo) * VR_A;

    // Query range check against the current fill
    assign w_bad = (CMPW'(i_req.right_pos) != CMPW'(r_fill))
                || (i_req.left_pos == '0)
                || (i_req.left_pos > i_req.right_pos);

    // Read addresses follow the next index so data lines up with the next step
    assign tree_raddr = ((n_pos != '0) && (n_pos <= IW'(MAX_ELEMS))) ? n_pos[TW-1:0] : '0;
    assign lp_raddr   = (32'(n_slot) < VALUE_RANGE) ? LW'(n_slot) : '0;

    // Write ports: clearing pass, walk updates or the last-position record
    always_comb begin
        tree_we    = 1'b0;
        tree_waddr = r_pos[TW-1:0];
        tree_wdata = alu_y[CW-1:0];
        lp_we      = 1'b0;
        lp_waddr   = LW'(r_slot);
        lp_wdata   = r_fill + PW'(1);
        if (r_state == S_CLEAR) begin
            tree_we    = (32'(r_clr) < TD);
            tree_waddr = TW'(r_clr);
            tree_wdata = '0;
            lp_we      = (32'(r_clr) < VALUE_RANGE);
            lp_waddr   = LW'(r_clr);
            lp_wdata   = '0;
        end else if ((r_state == S_DEC) || (r_state == S_INC)) begin
            tree_we = 1'b1;
        end else if (r_state == S_LPCHK) begin
            lp_we = 1'b1;
        end
    end

    // Operand selection for the shared adder
    always_comb begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        unique case (r_state)
            S_DEC: begin
                alu_op = ALU_SUB;
                alu_a  = ALW'(tree_rdata);
                alu_b  = ALW'(1);
            end
            S_INC: begin
                alu_a = ALW'(tree_rdata);
                alu_b = ALW'(1);
            end
            S_QA, S_QB: begin
                alu_a = ALW'(r_acc);
                alu_b = ALW'(tree_rdata);
            end
            S_QSUB: begin
                alu_op = ALU_SUB;
                alu_a  = ALW'(r_suma);
                alu_b  = ALW'(r_acc);
            end
            S_MODSUB: begin
                alu_op = ALU_SUB;
                alu_a  = ALW'(r_slot);
                alu_b  = w_quo_vr;
            end
            default: begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    // Sequencer next state
    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_fill    = r_fill;
        n_pos     = r_pos;
        n_slot    = r_slot;
        n_quo     = r_quo;
        n_acc     = r_acc;
        n_suma    = r_suma;
        n_lm1     = r_lm1;
        n_res_cnt = r_res_cnt;
        n_res_st  = r_res_st;
        n_ovalid  = r_ovalid;
        n_ocount  = r_ocount;
        n_ostatus = r_ostatus;

        // Result taken downstream
        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + CLRW'(1);
                if (r_clr == CLRW'(CLR_N - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_res_cnt = '0;
                    if (t_req_type'(i_req.req_type) == REQ_PUSH) begin
                        if (r_fill == PW'(MAX_ELEMS)) begin
                            n_res_st = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_slot = i_req.elem_value;
                            if (MOD_REQ) begin
                                n_state = S_MOD;
                            end else begin
                                n_state = S_LPCHK;
                            end
                        end
                    end else begin
                        if (w_bad) begin
                            n_res_st = ST_BAD;
                            n_state  = S_DONE;
                        end else begin
                            n_pos   = IW'(i_req.right_pos);
                            n_lm1   = PW'(i_req.left_pos - POS_W'(1));
                            n_acc   = '0;
                            n_state = S_QA;
                        end
                    end
                end
            end
            // Reduction of the value by VALUE_RANGE: quotient first, then the remainder
            S_MOD: begin
                n_quo   = w_quo;
                n_state = S_MODSUB;
            end
            S_MODSUB: begin
                n_slot  = alu_y[VW-1:0];
                n_state = S_LPCHK;
            end
            // Earlier position of the value is known; record the new one
            S_LPCHK: begin
                if (lp_rdata != '0) begin
                    n_pos   = IW'(lp_rdata);
                    n_state = S_DEC;
                end else begin
                    n_pos   = IW'(r_fill) + IW'(1);
                    n_state = S_INC;
                end
            end
            S_DEC: begin
                if (w_pos_up > IW'(MAX_ELEMS)) begin
                    n_state = S_INCSET;
                end else begin
                    n_pos = w_pos_up;
                end
            end
            // Turnaround so the first increment read never meets the last decrement write
            S_INCSET: begin
                n_pos   = IW'(r_fill) + IW'(1);
                n_state = S_INC;
            end
            S_INC: begin
                if (w_pos_up > IW'(MAX_ELEMS)) begin
                    n_fill   = r_fill + PW'(1);
                    n_res_st = ST_OK;
                    n_state  = S_DONE;
                end else begin
                    n_pos = w_pos_up;
                end
            end
            S_QA: begin
                n_acc = alu_y[CW-1:0];
                if (w_pos_dn == '0) begin
                    n_suma  = alu_y[CW-1:0];
                    n_acc   = '0;
                    n_pos   = IW'(r_lm1);
                    n_state = (r_lm1 != '0) ? S_QB : S_QSUB;
                end else begin
                    n_pos = w_pos_dn;
                end
            end
            S_QB: begin
                n_acc = alu_y[CW-1:0];
                if (w_pos_dn == '0) begin
                    n_state = S_QSUB;
                end else begin
                    n_pos = w_pos_dn;
                end
            end
            S_QSUB: begin
                n_res_cnt = COUNT_W'(alu_y[CW-1:0]);
                n_res_st  = ST_OK;
                n_state   = S_DONE;
            end
            // Post the result once the output register is free
            S_DONE: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid  = 1'b1;
                    n_ocount  = r_res_cnt;
                    n_ostatus = r_res_st;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_fill   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_fill   <= n_fill;
            r_ovalid <= n_ovalid;
        end
        r_pos     <= n_pos;
        r_slot    <= n_slot;
        r_quo     <= n_quo;
        r_acc     <= n_acc;
        r_suma    <= n_suma;
        r_lm1     <= n_lm1;
        r_res_cnt <= n_res_cnt;
        r_res_st  <= n_res_st;
        r_ocount  <= n_ocount;
        r_ostatus <= n_ostatus;
    end

    // Checks
    `FDRC_ASSERT(a_fill_bound, (r_fill <= PW'(MAX_ELEMS)), "fill beyond capacity")
    `FDRC_ASSERT(a_fill_step, 1'b1 |=> ((r_fill == $past(r_fill)) || (r_fill == $past(r_fill) + PW'(1))), "fill moved by more than one")
    `FDRC_ASSERT(a_walk_index, ((r_state == S_DEC) || (r_state == S_INC)) |-> ((r_pos != '0) && (r_pos <= IW'(MAX_ELEMS))), "tree write outside positions")
    `FDRC_ASSERT(a_query_no_write, ((r_state == S_QA) || (r_state == S_QB) || (r_state == S_QSUB)) |-> !tree_we, "tree written during a query")
    `FDRC_ASSERT(a_error_zero, (r_ovalid && (r_ostatus != ST_OK)) |-> (r_ocount == '0), "error result with nonzero count")

endmodule
